// ===== rtl/pfv_pkg.sv =====
// Shared types and constants for the PBM P1 file validator.
// No dependencies; imported by every module of the block.
package pfv_pkg;

  localparam int unsigned LINE_MAX_DEF = 255;
  localparam int unsigned MAX_DIM_DEF  = 4095;
  localparam int unsigned COUNT_W      = 25;

  // result codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_MAGIC = 3'd1;
  localparam logic [2:0] ERR_SIZE  = 3'd2;
  localparam logic [2:0] ERR_PIXEL = 3'd3;
  localparam logic [2:0] ERR_COUNT = 3'd4;
  localparam logic [2:0] ERR_JUNK  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } pfv_in_t;

  typedef struct packed {
    logic       file_valid;
    logic [2:0] error_code;
  } pfv_out_t;

endpackage

// ===== rtl/pfv_parser.sv =====
// Byte parser: header and body state, updated once per accepted word.
// Depends on pfv_pkg.
module pfv_parser
  import pfv_pkg::*;
#(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  parameter int unsigned MAX_DIM  = MAX_DIM_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  pfv_in_t  word_i,
  output logic     res_valid_o,
  output pfv_out_t res_o
);

  localparam int unsigned LEN_W  = $clog2(LINE_MAX + 1);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 2);
  localparam int unsigned GROW_W = DIM_W + 4;
  localparam int unsigned PROD_W = 2 * DIM_W;
  localparam int unsigned CMP_W  = (PROD_W > COUNT_W) ? PROD_W : COUNT_W;

  localparam logic [3:0] PH_MAGIC_P    = 4'd0;
  localparam logic [3:0] PH_MAGIC_ONE  = 4'd1;
  localparam logic [3:0] PH_MAGIC_REST = 4'd2;
  localparam logic [3:0] PH_SIZE_START = 4'd3;
  localparam logic [3:0] PH_WIDTH      = 4'd4;
  localparam logic [3:0] PH_GAP        = 4'd5;
  localparam logic [3:0] PH_SIGN       = 4'd6;
  localparam logic [3:0] PH_HEIGHT     = 4'd7;
  localparam logic [3:0] PH_TAIL       = 4'd8;
  localparam logic [3:0] PH_BODY       = 4'd9;
  localparam logic [3:0] PH_FAILED     = 4'd10;

  localparam logic [2:0] TK_BETWEEN    = 3'd0;
  localparam logic [2:0] TK_PLUS       = 3'd1;
  localparam logic [2:0] TK_MINUS      = 3'd2;
  localparam logic [2:0] TK_DIGITS_POS = 3'd3;
  localparam logic [2:0] TK_DIGITS_NEG = 3'd4;
  localparam logic [2:0] TK_STOPPED    = 3'd5;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    is_sign = (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // v*10 + d, saturating at MAX_DIM+1
  function automatic logic [DIM_W-1:0] grow(input logic [DIM_W-1:0] v, input logic [3:0] d);
    logic [GROW_W-1:0] n;
    n = ({4'b0000, v} * GROW_W'(10)) + {DIM_W'(0), d};
    if (n > GROW_W'(MAX_DIM)) grow = DIM_W'(MAX_DIM + 1);
    else                      grow = n[DIM_W-1:0];
  endfunction

  logic [3:0]         phase_q, phase_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [DIM_W-1:0]   width_q, width_d;
  logic [DIM_W-1:0]   height_q, height_d;
  logic               neg_q, neg_d;
  logic [2:0]         tok_q, tok_d;
  logic [1:0]         mag_q, mag_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [2:0]         err_q, err_d;

  logic [7:0]         c;
  logic [3:0]         dig;
  logic               in_digits, in_sign, tok_ok, dims_big;
  logic [COUNT_W-1:0] count_inc;
  logic [PROD_W-1:0]  product;
  logic               count_match;
  logic [2:0]         verdict, final_err;

  assign c         = word_i.data_byte;
  assign dig       = c[3:0];
  assign in_digits = (tok_q == TK_DIGITS_POS) || (tok_q == TK_DIGITS_NEG);
  assign in_sign   = (tok_q == TK_PLUS) || (tok_q == TK_MINUS);
  assign tok_ok    = (tok_q == TK_DIGITS_NEG) ? (mag_q == 2'd0) : (mag_q <= 2'd1);
  assign count_inc = (count_q == '1) ? count_q : count_q + COUNT_W'(1);
  assign dims_big  = (width_q > DIM_W'(MAX_DIM)) || (height_q > DIM_W'(MAX_DIM));
  assign product   = {DIM_W'(0), width_q} * {DIM_W'(0), height_q};

  // end-of-file verdict for a file that reached the body (or the end of the size line)
  always_comb begin
    count_match = (neg_q && (product != '0)) ? 1'b0 :
                  (CMP_W'(in_digits ? count_inc : count_q) == CMP_W'(product));
    if (in_digits && !tok_ok) verdict = ERR_PIXEL;
    else if (!count_match)    verdict = ERR_COUNT;
    else if (tok_q == TK_STOPPED || in_sign) verdict = ERR_JUNK;
    else                      verdict = ERR_NONE;
  end

  always_comb begin
    phase_d     = phase_q;
    len_d       = len_q;
    width_d     = width_q;
    height_d    = height_q;
    neg_d       = neg_q;
    tok_d       = tok_q;
    mag_d       = mag_q;
    count_d     = count_q;
    err_d       = err_q;
    final_err   = err_q;
    res_valid_o = 1'b0;

    if (accept_i && word_i.end_of_file) begin
      unique case (phase_q)
        PH_MAGIC_P, PH_MAGIC_ONE:                                   final_err = ERR_MAGIC;
        PH_MAGIC_REST, PH_SIZE_START, PH_WIDTH, PH_GAP, PH_SIGN:    final_err = ERR_SIZE;
        PH_HEIGHT, PH_TAIL: final_err = dims_big ? ERR_SIZE : verdict;
        PH_BODY:            final_err = verdict;
        default:            final_err = err_q;
      endcase
      res_valid_o = 1'b1;
      // back to the start of a new file
      phase_d  = PH_MAGIC_P;
      len_d    = '0;
      width_d  = '0;
      height_d = '0;
      neg_d    = 1'b0;
      tok_d    = TK_BETWEEN;
      mag_d    = 2'd0;
      count_d  = '0;
      err_d    = ERR_NONE;
    end else if (accept_i && phase_q != PH_FAILED) begin
      if (phase_q < PH_BODY && len_q >= LEN_W'(LINE_MAX)) begin
        err_d   = (phase_q <= PH_MAGIC_REST) ? ERR_MAGIC : ERR_SIZE;
        phase_d = PH_FAILED;
      end else begin
        if (phase_q < PH_BODY) len_d = len_q + LEN_W'(1);
        unique case (phase_q)
          PH_MAGIC_P: begin
            if (c == CH_P) phase_d = PH_MAGIC_ONE;
            else begin err_d = ERR_MAGIC; phase_d = PH_FAILED; end
          end
          PH_MAGIC_ONE: begin
            if (c == CH_ONE) phase_d = PH_MAGIC_REST;
            else begin err_d = ERR_MAGIC; phase_d = PH_FAILED; end
          end
          PH_MAGIC_REST: begin
            if (c == CH_LF) begin
              phase_d = PH_SIZE_START;
              len_d   = '0;
            end else if (c != CH_SPACE) begin
              err_d = ERR_MAGIC; phase_d = PH_FAILED;
            end
          end
          PH_SIZE_START: begin
            if (is_digit(c)) begin
              width_d = grow('0, dig);
              phase_d = PH_WIDTH;
            end else begin
              err_d = ERR_SIZE; phase_d = PH_FAILED;
            end
          end
          PH_WIDTH, PH_GAP: begin
            if (is_digit(c)) begin
              if (phase_q == PH_WIDTH) width_d = grow(width_q, dig);
              else begin
                height_d = grow('0, dig);
                phase_d  = PH_HEIGHT;
              end
            end else if (c == CH_LF) begin
              err_d = ERR_SIZE; phase_d = PH_FAILED;
            end else if (is_space(c)) begin
              phase_d = PH_GAP;
            end else if (is_sign(c)) begin
              neg_d   = (c == CH_MINUS);
              phase_d = PH_SIGN;
            end else begin
              err_d = ERR_SIZE; phase_d = PH_FAILED;
            end
          end
          PH_SIGN: begin
            if (is_digit(c)) begin
              height_d = grow('0, dig);
              phase_d  = PH_HEIGHT;
            end else begin
              err_d = ERR_SIZE; phase_d = PH_FAILED;
            end
          end
          PH_HEIGHT, PH_TAIL: begin
            if (phase_q == PH_HEIGHT && is_digit(c)) begin
              height_d = grow(height_q, dig);
            end else if (c == CH_LF) begin
              if (dims_big) begin err_d = ERR_SIZE; phase_d = PH_FAILED; end
              else phase_d = PH_BODY;
            end else if (is_space(c)) begin
              phase_d = PH_TAIL;
            end else begin
              err_d = ERR_SIZE; phase_d = PH_FAILED;
            end
          end
          PH_BODY: begin
            if (tok_q != TK_STOPPED) begin
              if (is_digit(c)) begin
                if (tok_q == TK_MINUS) tok_d = TK_DIGITS_NEG;
                else if (!in_digits)   tok_d = TK_DIGITS_POS;
                if (mag_q == 2'd0) mag_d = (dig > 4'd1) ? 2'd2 : dig[1:0];
                else               mag_d = 2'd2;
              end else if (in_digits && !tok_ok) begin
                err_d = ERR_PIXEL; phase_d = PH_FAILED;
              end else begin
                if (in_digits) begin
                  count_d = count_inc;
                  tok_d   = TK_BETWEEN;
                  mag_d   = 2'd0;
                end
                if (is_space(c)) begin
                  if (in_sign) tok_d = TK_STOPPED;
                end else if (is_sign(c)) begin
                  if (in_sign) tok_d = TK_STOPPED;
                  else         tok_d = (c == CH_MINUS) ? TK_MINUS : TK_PLUS;
                end else begin
                  tok_d = TK_STOPPED;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res_o.error_code = final_err;
  assign res_o.file_valid = (final_err == ERR_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC_P;
      len_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      neg_q    <= 1'b0;
      tok_q    <= TK_BETWEEN;
      mag_q    <= 2'd0;
      count_q  <= '0;
      err_q    <= ERR_NONE;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      width_q  <= width_d;
      height_q <= height_d;
      neg_q    <= neg_d;
      tok_q    <= tok_d;
      mag_q    <= mag_d;
      count_q  <= count_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== rtl/pfv_out_reg.sv =====
// Result register: holds one verdict word until the sink takes it.
// Depends on pfv_pkg.
module pfv_out_reg
  import pfv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  pfv_out_t res_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pfv_out_t out_data_o
);

  logic     valid_q, valid_d;
  pfv_out_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (valid_q && !out_stall_i) valid_d = 1'b0;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/pbm_p1_file_validator_core.sv =====
// Top level of the PBM P1 file validator: byte parser and result register.
// Depends on pfv_pkg, pfv_parser and pfv_out_reg.
//
//  port group   dir  word         meaning
//  in_*         in   pfv_in_t     one file byte, or the end-of-file marker
//  out_*        out  pfv_out_t    verdict for a file, one per end-of-file marker
//
// One word is taken every clock unless an end marker is held off; each byte
// is folded into the parse state in the cycle it arrives, and the verdict
// enters the result register with the end marker and shows the cycle after.
// Reset (rst_ni low, asynchronous) returns the parser to "expect 'P'" and
// empties the result register. Only an end marker can be held off: it stalls
// while an untaken verdict sits in the result register; ordinary bytes flow on.
module pbm_p1_file_validator_core
  import pfv_pkg::*;
#(
  parameter int unsigned LINE_MAX = LINE_MAX_DEF,
  parameter int unsigned MAX_DIM  = MAX_DIM_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pfv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pfv_out_t out_data_o
);

  logic     accept;
  logic     res_valid;
  pfv_out_t res;

  // an end marker needs room in the result register; the slot frees up in
  // the same cycle the sink takes the old verdict
  assign in_stall_o = out_valid_o && out_stall_i && in_data_i.end_of_file;
  assign accept     = in_valid_i && !in_stall_o;

  pfv_parser #(
    .LINE_MAX (LINE_MAX),
    .MAX_DIM  (MAX_DIM)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pfv_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
